/* hdl/nmea_pkg.sv */
// ============================================================================
// nmea_pkg
// Shared types and constants for the NMEA sentence checker.
// ============================================================================
package nmea_pkg;

    localparam int ID_CHARS = 8;
    localparam int LEN_W    = 11;
    localparam int IDC_W    = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] LINE_MAX      = 11'd1024;
    localparam logic [IDC_W-1:0] ID_COUNT_MAX  = 10'd1023;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // register map: word index taken from paddr[2]
    localparam logic REG_MAX_LINE_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        CKS_NONE     = 2'd0,
        CKS_MISMATCH = 2'd1,
        CKS_VALID    = 2'd2
    } cks_state_t;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_newline;
        logic       is_cr;
        logic       is_start;
        logic       is_star;
        logic       is_comma;
        logic       hex_ok;
        logic [3:0] hex_val;
    } char_class_t;

    typedef struct packed {
        cks_state_t              cks;
        logic [8*ID_CHARS-1:0]   id;
        logic [IDC_W-1:0]        id_len;
        logic [LEN_W-1:0]        sent_len;
        logic [7:0]              xor_sum;
    } result_t;

endpackage

/* hdl/nmea_front.sv */
// ============================================================================
// nmea_front
// Drops NUL bytes and classifies the rest for the back end.
// ============================================================================
module nmea_front
    import nmea_pkg::*;
(
    input  logic         in_valid,
    input  logic [7:0]   rx_byte,
    input  logic         q_full,
    output logic         in_stall,
    output logic         q_push,
    output char_class_t  q_item
);

    always_comb
    begin
        q_item.data       = rx_byte;
        q_item.is_newline = (rx_byte == CH_NEWLINE);
        q_item.is_cr      = (rx_byte == CH_CR);
        q_item.is_start   = (rx_byte == CH_DOLLAR) || (rx_byte == CH_BANG);
        q_item.is_star    = (rx_byte == CH_STAR);
        q_item.is_comma   = (rx_byte == CH_COMMA);
        q_item.hex_ok     = 1'b1;
        q_item.hex_val    = 4'd0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
        begin
            q_item.hex_val = 4'(rx_byte - 8'h30);
        end
        else if (rx_byte >= 8'h41 && rx_byte <= 8'h46)
        begin
            q_item.hex_val = 4'(rx_byte - 8'h37);
        end
        else if (rx_byte >= 8'h61 && rx_byte <= 8'h66)
        begin
            q_item.hex_val = 4'(rx_byte - 8'h57);
        end
        else
        begin
            q_item.hex_ok = 1'b0;
        end
    end

    assign in_stall = q_full;
    // NUL transfers are accepted and dropped here
    assign q_push   = in_valid && !q_full && (rx_byte != CH_NUL);

endmodule

/* hdl/nmea_queue.sv */
// ============================================================================
// nmea_queue
// Small FIFO of classified bytes between front and back.
// ============================================================================
module nmea_queue
    import nmea_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  char_class_t  push_item,
    input  logic         pop,
    output logic         full,
    output logic         head_valid,
    output char_class_t  head_item
);

    char_class_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wptr_reg;
    logic [QPTR_W-1:0]        rptr_reg;
    logic [QCNT_W-1:0]        count_reg;
    logic [QCNT_W-1:0]        count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && pop && head_valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wptr_reg + QPTR_W'(1);
            end
            if (pop && head_valid)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rptr_reg];

endmodule

/* hdl/nmea_back.sv */
// ============================================================================
// nmea_back
// Line framing, body XOR, id capture and checksum verdict; result register.
// ============================================================================
module nmea_back
    import nmea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LEN_W-1:0]  max_len,
    input  logic              q_valid,
    input  char_class_t       q_item,
    output logic              q_pop,
    input  logic              out_stall,
    output logic              out_valid,
    output result_t           out_result
);

    logic [LEN_W-1:0]        line_count_reg, line_count_next;
    logic                    start_seen_reg, start_seen_next;
    logic                    star_seen_reg,  star_seen_next;
    logic                    id_closed_reg,  id_closed_next;
    logic [7:0]              xor_acc_reg,    xor_acc_next;
    logic [1:0]              hex_seen_reg,   hex_seen_next;
    logic [7:0]              hex_digits_reg, hex_digits_next;
    logic                    hex_bad_reg,    hex_bad_next;
    logic [8*ID_CHARS-1:0]   id_store_reg,   id_store_next;
    logic [IDC_W-1:0]        id_count_reg,   id_count_next;
    logic [LEN_W-1:0]        body_count_reg, body_count_next;
    logic [LEN_W-1:0]        pending_cr_reg, pending_cr_next;
    logic                    out_valid_reg;
    result_t                 result_reg;

    logic [LEN_W-1:0]        limit;
    logic                    out_free;
    logic                    load_out;
    logic                    do_clear;
    logic [IDC_W+1:0]        cr_end;
    logic [IDC_W-1:0]        idc_cr;
    cks_state_t              verdict;

    assign limit    = (max_len > LINE_MAX) ? LINE_MAX : max_len;
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = q_valid && (!q_item.is_newline || out_free);

    // id slots covered by held-back carriage returns end here
    assign cr_end = {2'b00, id_count_reg} + {1'b0, pending_cr_reg};
    assign idc_cr = (cr_end > {2'b00, ID_COUNT_MAX}) ? ID_COUNT_MAX : cr_end[IDC_W-1:0];

    always_comb
    begin
        verdict = CKS_NONE;
        if (star_seen_reg && hex_seen_reg == 2'd2 && !hex_bad_reg)
        begin
            verdict = (xor_acc_reg == hex_digits_reg) ? CKS_VALID : CKS_MISMATCH;
        end
    end

    always_comb
    begin
        line_count_next = line_count_reg;
        start_seen_next = start_seen_reg;
        star_seen_next  = star_seen_reg;
        id_closed_next  = id_closed_reg;
        xor_acc_next    = xor_acc_reg;
        hex_seen_next   = hex_seen_reg;
        hex_digits_next = hex_digits_reg;
        hex_bad_next    = hex_bad_reg;
        id_store_next   = id_store_reg;
        id_count_next   = id_count_reg;
        body_count_next = body_count_reg;
        pending_cr_next = pending_cr_reg;
        load_out        = 1'b0;
        do_clear        = 1'b0;

        if (q_pop)
        begin
            if (q_item.is_newline)
            begin
                load_out = start_seen_reg;
                do_clear = 1'b1;
            end
            else if (line_count_reg >= limit)
            begin
                do_clear = 1'b1;
            end
            else
            begin
                line_count_next = line_count_reg + LEN_W'(1);
                if (!start_seen_reg)
                begin
                    if (q_item.is_start)
                    begin
                        start_seen_next = 1'b1;
                        body_count_next = LEN_W'(1);
                    end
                end
                else if (q_item.is_cr)
                begin
                    pending_cr_next = pending_cr_reg + LEN_W'(1);
                end
                else
                begin
                    // held carriage returns become ordinary body characters
                    pending_cr_next = '0;
                    body_count_next = body_count_reg + pending_cr_reg + LEN_W'(1);
                    if (!star_seen_reg)
                    begin
                        if (pending_cr_reg[0])
                        begin
                            xor_acc_next = xor_acc_reg ^ CH_CR;
                        end
                    end
                    else if (pending_cr_reg != '0 && hex_seen_reg < 2'd2)
                    begin
                        hex_bad_next  = 1'b1;
                        hex_seen_next = (pending_cr_reg >= LEN_W'(2)) ? 2'd2
                                                                     : hex_seen_reg + 2'd1;
                    end
                    if (!id_closed_reg)
                    begin
                        for (int k = 0; k < ID_CHARS; k++)
                        begin
                            if ((IDC_W+2)'(k) >= {2'b00, id_count_reg} && (IDC_W+2)'(k) < cr_end)
                            begin
                                id_store_next[8*k +: 8] = CH_CR;
                            end
                        end
                        id_count_next = idc_cr;
                    end

                    // the character itself
                    if (!star_seen_reg)
                    begin
                        if (q_item.is_star)
                        begin
                            star_seen_next = 1'b1;
                        end
                        else
                        begin
                            xor_acc_next = xor_acc_next ^ q_item.data;
                        end
                    end
                    else if (hex_seen_next < 2'd2)
                    begin
                        hex_seen_next = hex_seen_next + 2'd1;
                        if (!q_item.hex_ok)
                        begin
                            hex_bad_next = 1'b1;
                        end
                        else
                        begin
                            hex_digits_next = {hex_digits_reg[3:0], q_item.hex_val};
                        end
                    end
                    if (!id_closed_reg)
                    begin
                        if (q_item.is_comma || q_item.is_star)
                        begin
                            id_closed_next = 1'b1;
                        end
                        else
                        begin
                            for (int k = 0; k < ID_CHARS; k++)
                            begin
                                if (IDC_W'(k) == id_count_next)
                                begin
                                    id_store_next[8*k +: 8] = q_item.data;
                                end
                            end
                            if (id_count_next < ID_COUNT_MAX)
                            begin
                                id_count_next = id_count_next + IDC_W'(1);
                            end
                        end
                    end
                end
            end
        end

        if (do_clear)
        begin
            line_count_next = '0;
            start_seen_next = 1'b0;
            star_seen_next  = 1'b0;
            id_closed_next  = 1'b0;
            xor_acc_next    = '0;
            hex_seen_next   = '0;
            hex_digits_next = '0;
            hex_bad_next    = 1'b0;
            id_store_next   = '0;
            id_count_next   = '0;
            body_count_next = '0;
            pending_cr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            start_seen_reg <= 1'b0;
            star_seen_reg  <= 1'b0;
            id_closed_reg  <= 1'b0;
            xor_acc_reg    <= '0;
            hex_seen_reg   <= '0;
            hex_digits_reg <= '0;
            hex_bad_reg    <= 1'b0;
            id_store_reg   <= '0;
            id_count_reg   <= '0;
            body_count_reg <= '0;
            pending_cr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            start_seen_reg <= start_seen_next;
            star_seen_reg  <= star_seen_next;
            id_closed_reg  <= id_closed_next;
            xor_acc_reg    <= xor_acc_next;
            hex_seen_reg   <= hex_seen_next;
            hex_digits_reg <= hex_digits_next;
            hex_bad_reg    <= hex_bad_next;
            id_store_reg   <= id_store_next;
            id_count_reg   <= id_count_next;
            body_count_reg <= body_count_next;
            pending_cr_reg <= pending_cr_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg.cks      <= verdict;
            result_reg.id       <= id_store_reg;
            result_reg.id_len   <= id_count_reg;
            result_reg.sent_len <= body_count_reg;
            result_reg.xor_sum  <= xor_acc_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

/* hdl/nmea_sentence_checker.sv */
// ============================================================================
// nmea_sentence_checker
// NMEA 0183 framing and checksum check, one byte per cycle when not stalled.
// ============================================================================
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ------------------------------------
//  in       input      in_valid / in_stall   rx_byte
//  out      output     out_valid / out_stall checksum_status, msg_id,
//                                            id_length, sentence_length,
//                                            computed_checksum
//  cfg      input      APB, pready always 1  max_line_length at byte addr 0
//
//  One byte transfer per cycle unless stalled; the back end updates all
//  line state for each byte it takes from a two-entry queue.
//  A sentence result is loaded into the output register at the edge where its
//  newline leaves the queue. While a prior result is still held by
//  out_stall the newline waits at the queue head; the byte behind it
//  fills the second entry, then in_stall rises.
//  Reset (rst_n low, async) empties the queue and clears all line state;
//  max_line_length returns to 1024. No clearing pass is needed.
//
module nmea_sentence_checker
    import nmea_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // input byte channel
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    // result channel
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    checksum_status,
    output logic [63:0]   msg_id,
    output logic [9:0]    id_length,
    output logic [10:0]   sentence_length,
    output logic [7:0]    computed_checksum,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [LEN_W-1:0]  max_len_reg;
    logic              cfg_write;

    logic              q_full;
    logic              q_push;
    char_class_t       q_in_item;
    logic              q_pop;
    logic              q_head_valid;
    char_class_t       q_head_item;
    result_t           result;

    // ---------------- configuration register ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_LINE_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LINE_MAX;
        end
        else if (cfg_write)
        begin
            max_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_LINE_LENGTH) ? {{(32-LEN_W){1'b0}}, max_len_reg}
                                                      : 32'd0;

    // ---------------- front: NUL drop and classification ----------------
    nmea_front u_front
    (
        .in_valid (in_valid),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .in_stall (in_stall),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    // ---------------- decoupling queue ----------------
    nmea_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    // ---------------- back: line state and result register ----------------
    nmea_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_len    (max_len_reg),
        .q_valid    (q_head_valid),
        .q_item     (q_head_item),
        .q_pop      (q_pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_result (result)
    );

    assign checksum_status   = result.cks;
    assign msg_id            = result.id;
    assign id_length         = result.id_len;
    assign sentence_length   = result.sent_len;
    assign computed_checksum = result.xor_sum;

endmodule

/* tb/sv/nmea_sentence_checker_test.sv */
// ============================================================================
// nmea_sentence_checker_test
// Self-checking testbench: byte stream in, one sentence result per framed line.
// Bytes go out through a clocked driver fed from a queue. Each accepted byte
// runs through a line predictor that queues the expected sentence results.
// A clocked monitor compares every result transfer, field by field, with the
// oldest expectation.
// ============================================================================
`timescale 1ns / 1ps

module nmea_sentence_checker_test;
    import nmea_pkg::*;

    localparam int DRAIN_CYCLES = 16;      // queue + output register, with margin
    localparam int LIMIT_CYCLES = 200000;  // watchdog
    localparam int PHASE_BYTES  = 40;      // minimum count of non-NUL bytes per random phase

    // how the checksum tail of a generated sentence is formed
    typedef enum int {
        CK_GOOD_UC,
        CK_GOOD_LC,
        CK_WRONG,
        CK_BAD_HEX,
        CK_ONE_DIGIT,
        CK_STAR_ONLY,
        CK_OMIT
    } cks_form_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  checksum_status;
    logic [63:0] msg_id;
    logic [9:0]  id_length;
    logic [10:0] sentence_length;
    logic [7:0]  computed_checksum;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    nmea_sentence_checker dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .checksum_status   (checksum_status),
        .msg_id            (msg_id),
        .id_length         (id_length),
        .sentence_length   (sentence_length),
        .computed_checksum (computed_checksum),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus and checking state
    // ------------------------------------------------------------------------
    logic [7:0] tx_bytes[$];          // bytes waiting for the driver
    result_t    pending_sentences[$]; // predicted results, oldest first
    result_t    want_sentence;
    int         bytes_queued = 0;     // non-NUL bytes handed to the driver
    int         errors = 0;
    int         cycles = 0;
    int         src_idle_pct = 0;     // chance per cycle that the sender idles
    int         snk_stall_pct = 0;    // chance per cycle that the receiver stalls
    logic       in_fire = 1'b0;       // byte transfer at the last rising edge

    // ------------------------------------------------------------------------
    // Line predictor: its own copy of the limit register and line state
    // ------------------------------------------------------------------------
    logic [10:0] limit_reg = LINE_MAX;
    int          ln_count;      // kept characters of the current line
    logic        in_sentence;   // start marker seen
    logic        after_star;
    logic        id_done;       // id closed by ',' or '*'
    logic [7:0]  body_xor;
    int          hex_count;     // characters looked at after the star, 0..2
    logic [7:0]  hex_val;
    logic        hex_err;
    logic [63:0] id_chars;
    int          id_len;
    int          sent_len;
    int          held_cr;       // CRs not yet known to be inside the sentence

    function automatic void clear_line();
        ln_count    = 0;
        in_sentence = 1'b0;
        after_star  = 1'b0;
        id_done     = 1'b0;
        body_xor    = 8'h00;
        hex_count   = 0;
        hex_val     = 8'h00;
        hex_err     = 1'b0;
        id_chars    = 64'd0;
        id_len      = 0;
        sent_len    = 0;
        held_cr     = 0;
    endfunction

    // one sentence character after the start marker
    task automatic body_char(input logic [7:0] c);
        int   nib;
        logic ok;
        sent_len++;
        if (!after_star)
        begin
            if (c == CH_STAR)
                after_star = 1'b1;
            else
                body_xor = body_xor ^ c;
        end
        else if (hex_count < 2)
        begin
            hex_count++;
            ok  = 1'b1;
            nib = 0;
            if (c >= "0" && c <= "9")
                nib = int'(c) - int'(8'h30);
            else if (c >= "A" && c <= "F")
                nib = int'(c) - int'(8'h41) + 10;
            else if (c >= "a" && c <= "f")
                nib = int'(c) - int'(8'h61) + 10;
            else
                ok = 1'b0;
            if (ok)
                hex_val = {hex_val[3:0], 4'(nib)};
            else
                hex_err = 1'b1;
        end
        if (!id_done)
        begin
            if (c == CH_COMMA || c == CH_STAR)
                id_done = 1'b1;
            else
            begin
                if (id_len < ID_CHARS)
                    id_chars[8*id_len +: 8] = c;
                if (id_len < 1023)
                    id_len++;
            end
        end
    endtask

    // advance the line state by one accepted byte; a newline may close a sentence
    task automatic scan_byte(input logic [7:0] c);
        result_t r;
        int      lim;
        if (c == CH_NUL)
            return;
        if (c == CH_NEWLINE)
        begin
            if (in_sentence)
            begin
                r.cks = CKS_NONE;
                if (after_star && hex_count == 2 && !hex_err)
                    r.cks = (body_xor == hex_val) ? CKS_VALID : CKS_MISMATCH;
                r.id       = id_chars;
                r.id_len   = id_len[9:0];
                r.sent_len = sent_len[10:0];
                r.xor_sum  = body_xor;
                pending_sentences.insert(pending_sentences.size(), r);
            end
            clear_line();
            return;
        end
        // limits past the line buffer act as the buffer size
        lim = (limit_reg > LINE_MAX) ? int'(LINE_MAX) : int'(limit_reg);
        if (ln_count >= lim)
        begin
            // overflow: the line and this byte are gone
            clear_line();
            return;
        end
        ln_count++;
        if (!in_sentence)
        begin
            if (c == CH_DOLLAR || c == CH_BANG)
            begin
                in_sentence = 1'b1;
                sent_len    = 1;
            end
            return;
        end
        // CRs only count once something other than CR follows them
        if (c == CH_CR)
            held_cr++;
        else
        begin
            while (held_cr > 0)
            begin
                body_char(CH_CR);
                held_cr--;
            end
            body_char(c);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
        if (b != CH_NUL)
            bytes_queued++;
    endtask

    // text with the odd NUL sprinkled in; the block must drop them
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            if ($urandom_range(99) < 3)
                add_byte(CH_NUL);
            add_byte(8'(s[i]));
        end
    endtask

    // head is any junk plus the start marker; the checksum is over body only
    task automatic add_nmea(input string head, input string body,
                            input cks_form_t form, input int crs);
        logic [7:0] x;
        string      s;
        x = 8'h00;
        for (int i = 0; i < body.len(); i++)
            x = x ^ 8'(body[i]);
        s = {head, body};
        case (form)
            CK_GOOD_UC:   s = {s, $sformatf("*%02X", x)};
            CK_GOOD_LC:   s = {s, $sformatf("*%02x", x)};
            CK_WRONG:     s = {s, $sformatf("*%02X", x ^ 8'($urandom_range(255, 1)))};
            CK_BAD_HEX:
            begin
                if ($urandom_range(1) != 0)
                    s = {s, $sformatf("*%1Xg", x[7:4])};
                else
                    s = {s, $sformatf("*Z%1X", x[3:0])};
            end
            CK_ONE_DIGIT: s = {s, $sformatf("*%1X", x[7:4])};
            CK_STAR_ONLY: s = {s, "*"};
            default:      ;
        endcase
        repeat (crs) s = {s, "\015"};
        add_text({s, "\n"});
    endtask

    // mostly well-formed sentences with random content, some pure noise lines
    task automatic add_random_sentence();
        string      head;
        string      body;
        logic [7:0] ch;
        cks_form_t  form;
        if ($urandom_range(99) < 12)
        begin
            // raw bytes over the full range, newline included
            repeat ($urandom_range(10)) add_byte(8'($urandom_range(255)));
            add_byte(CH_NEWLINE);
            return;
        end
        head = ($urandom_range(3) == 0) ? "!" : "$";
        if ($urandom_range(99) < 15)
            head = {$sformatf("%c", 8'($urandom_range(126, 32))), head};
        body = "";
        // id: upper case letters and digits, sometimes past the eight kept
        repeat ($urandom_range(9))
        begin
            if ($urandom_range(1) != 0)
                ch = 8'($urandom_range(90, 65));
            else
                ch = 8'($urandom_range(57, 48));
            body = $sformatf("%s%c", body, ch);
        end
        repeat ($urandom_range(3))
        begin
            body = {body, ","};
            repeat ($urandom_range(4))
            begin
                ch = 8'($urandom_range(126, 32));
                if (ch == CH_STAR)
                    ch = CH_COMMA;
                if ($urandom_range(99) < 8)
                    ch = CH_CR;
                body = $sformatf("%s%c", body, ch);
            end
        end
        if ($urandom_range(1) != 0)
            form = CK_GOOD_UC;
        else
            form = cks_form_t'($urandom_range(CK_OMIT));
        add_nmea(head, body, form, $urandom_range(2));
    endtask

    // ------------------------------------------------------------------------
    // Configuration write: setup then access cycle
    // ------------------------------------------------------------------------
    task automatic write_line_limit(input logic [10:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_LINE_LENGTH, 2'b00};
        pwdata  <= {21'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        limit_reg = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every byte taken, every result seen, then let the pipeline run dry
    task automatic settle();
        while (tx_bytes.size() != 0 || in_valid || pending_sentences.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: changes inputs at the falling edge. A byte stays on the port
    // until its transfer; idle and stall decisions are made per cycle.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (tx_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                in_valid <= 1'b1;
                rx_byte  <= tx_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                scan_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (pending_sentences.size() == 0)
                begin
                    $error("result transfer with nothing pending: id %h length %0d",
                           msg_id, sentence_length);
                    errors++;
                end
                else
                begin
                    want_sentence = pending_sentences.pop_front();
                    if (checksum_status !== want_sentence.cks)
                    begin
                        $error("checksum_status: expected %0d, got %0d",
                               want_sentence.cks, checksum_status);
                        errors++;
                    end
                    if (msg_id !== want_sentence.id)
                    begin
                        $error("msg_id: expected %h, got %h",
                               want_sentence.id, msg_id);
                        errors++;
                    end
                    if (id_length !== want_sentence.id_len)
                    begin
                        $error("id_length: expected %0d, got %0d",
                               want_sentence.id_len, id_length);
                        errors++;
                    end
                    if (sentence_length !== want_sentence.sent_len)
                    begin
                        $error("sentence_length: expected %0d, got %0d",
                               want_sentence.sent_len, sentence_length);
                        errors++;
                    end
                    if (computed_checksum !== want_sentence.xor_sum)
                    begin
                        $error("computed_checksum: expected %h, got %h",
                               want_sentence.xor_sum, computed_checksum);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    int lim_tab[5] = '{1024, 24, 2047, 80, 16};
    int src_tab[5] = '{0, 84, 0, 10, 0};
    int snk_tab[5] = '{0, 0, 84, 10, 84};

    initial
    begin
        int start_count;
        clear_line();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed sentences at the reset limit, no idling
        add_nmea("$", "GPGGA,123519,4807.038,N", CK_GOOD_UC, 1);
        add_nmea("!", "AIVDM,1,1,,A", CK_GOOD_LC, 0);
        add_nmea("$", "GPRMC,A", CK_WRONG, 2);
        add_nmea("$", "GPGLL", CK_BAD_HEX, 0);
        add_nmea("$", "X", CK_ONE_DIGIT, 0);
        add_nmea("$", "ABC", CK_STAR_ONLY, 0);
        add_nmea("$", "GPVTG,1,2", CK_OMIT, 1);
        add_nmea("$", "LONGIDENTIFIER,1", CK_GOOD_UC, 0);
        add_nmea("$", "", CK_OMIT, 0);                 // marker alone
        add_nmea("$", "", CK_GOOD_UC, 0);              // empty body, checksum 00
        add_nmea("junk$", "$GP,1", CK_GOOD_UC, 0);     // junk, then marker as body
        add_nmea("$", "GP\015\015A,1\015", CK_GOOD_UC, 2); // carriage returns inside
        add_text("$GP\015\015\015\n");                 // only trailing returns
        add_text("\015\015\n\nhello, world\n");        // no marker, empty lines
        add_text("$A*1*2\n");                          // second star among digits
        add_text("!ID!,x*");
        add_byte(CH_NUL);
        add_text("zz\n");
        add_text("$P");
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(8'h7F);
        add_byte(CH_NEWLINE);
        settle();

        // a sentence that just fits a short limit, then a line that overflows
        src_idle_pct  = 10;
        snk_stall_pct = 10;
        write_line_limit(11'd24);
        add_byte(CH_DOLLAR);
        repeat (23) add_byte(8'h41);
        add_byte(CH_NEWLINE);
        add_byte(CH_DOLLAR);
        repeat (24) add_byte(8'h42);
        add_text("$OK*");
        add_text("\n");
        settle();

        // limit above the buffer size acts as the buffer size
        write_line_limit(11'd2047);
        add_byte(CH_BANG);
        repeat (30) add_byte(8'h43);
        add_byte(CH_NEWLINE);
        settle();

        // zero limit drops everything
        src_idle_pct  = 0;
        snk_stall_pct = 84;
        write_line_limit(11'd0);
        add_nmea("$", "GPZDA,1", CK_GOOD_UC, 1);
        add_text("$\n!\n");
        settle();

        // limit of one: only a bare marker survives
        write_line_limit(11'd1);
        add_text("$\n!\n$A\n\nA\n");
        settle();

        // random phases over limits and idle patterns
        for (int k = 0; k < 5; k++)
        begin
            write_line_limit(11'(lim_tab[k]));
            src_idle_pct  = src_tab[k];
            snk_stall_pct = snk_tab[k];
            start_count   = bytes_queued;
            while (bytes_queued - start_count < PHASE_BYTES)
                add_random_sentence();
            settle();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
hdl/nmea_pkg.sv
hdl/nmea_front.sv
hdl/nmea_queue.sv
hdl/nmea_back.sv
hdl/nmea_sentence_checker.sv
tb/sv/nmea_sentence_checker_test.sv
